// ===== rtl/ttar_pkg.sv =====
// Shared types, constants and helpers for the tensor tile address remap block.
package ttar_pkg;

    localparam int DIM_BITS      = 16;
    localparam int INDEX_BITS    = 32;
    localparam int OUT_IDX_BITS  = 32;
    localparam int VAL_BITS      = 16;
    localparam int PB_BITS       = 32;
    localparam int RB_BITS       = 17;
    localparam int COL_BITS      = DIM_BITS + 1;
    localparam int ROW_BITS      = PB_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = QPTR_BITS + 1;
    localparam int DIV_CNT_BITS  = $clog2(PB_BITS);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DIM_N       = 3'd0,
        CFG_DIM_C       = 3'd1,
        CFG_DIM_H       = 3'd2,
        CFG_DIM_W       = 3'd3,
        CFG_PLANE_BYTES = 3'd4,
        CFG_ROW_BYTES   = 3'd5,
        CFG_DIRECTION   = 3'd6
    } t_cfg_reg;

    typedef enum logic {
        DIR_TILE   = 1'b0,
        DIR_UNTILE = 1'b1
    } t_dir;

    typedef enum logic [1:0] {
        DIV_LOAD,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    // One request handed from the front to the address pipeline.
    typedef struct packed {
        logic [VAL_BITS-1:0] value;
        logic                last;
        logic [DIM_BITS-1:0] batch;
        logic [DIM_BITS-1:0] chan;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic [DIM_BITS-1:0] nc;
        logic [ROW_BITS-1:0] x;   // rows per plane (tiled) or H (dense)
        logic [COL_BITS-1:0] y;   // slots per row (tiled) or W (dense)
    } t_item;

    typedef struct packed {
        logic start;    // every counter at zero: a new tensor begins
        logic emit;     // current request produces a result
        logic last;     // current request is the final element
        logic untile;
    } t_front_status;

    function automatic logic [DIM_BITS-1:0] at_least_one(input logic [DIM_BITS-1:0] v);
        return (v == '0) ? DIM_BITS'(1) : v;
    endfunction

endpackage

// ===== rtl/ttar_div.sv =====
// Restoring divider, one quotient bit per cycle: rows per plane = plane_bytes / row_bytes.
module ttar_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  logic [ttar_pkg::PB_BITS-1:0]   i_plane_bytes,
    input  logic [ttar_pkg::RB_BITS-1:0]   i_row_bytes,
    output logic [ttar_pkg::PB_BITS-1:0]   o_quot,
    output logic                           o_done
);
    import ttar_pkg::*;

    t_div_state              r_state, n_state;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [RB_BITS:0]        r_rem, n_rem;
    logic [PB_BITS-1:0]      r_quot, n_quot;
    logic [RB_BITS-1:0]      r_divisor, n_divisor;

    logic [RB_BITS:0]        rem_shift;
    logic [RB_BITS:0]        rem_diff;
    logic                    fits;

    assign rem_shift = {r_rem[RB_BITS-1:0], r_quot[PB_BITS-1]};
    assign fits      = rem_shift >= {1'b0, r_divisor};
    assign rem_diff  = rem_shift - {1'b0, r_divisor};

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_quot    = r_quot;
        n_divisor = r_divisor;
        case (r_state)
            DIV_LOAD: begin
                n_rem     = '0;
                n_quot    = i_plane_bytes;
                n_divisor = (i_row_bytes < RB_BITS'(2)) ? RB_BITS'(2) : i_row_bytes;
                n_cnt     = '0;
                n_state   = DIV_RUN;
            end
            DIV_RUN: begin
                n_rem  = fits ? rem_diff : rem_shift;
                n_quot = {r_quot[PB_BITS-2:0], fits};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(PB_BITS - 1)) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: begin
                n_state = DIV_DONE;
            end
            default: begin
                n_state = DIV_LOAD;
            end
        endcase
        if (i_restart) begin
            n_state = DIV_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quot    <= n_quot;
        r_divisor <= n_divisor;
    end

    assign o_quot = r_quot;
    assign o_done = (r_state == DIV_DONE);

endmodule

// ===== rtl/ttar_front.sv =====
// Front end: config registers, N/C/H/W counters, request classification.
module ttar_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ttar_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [ttar_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [ttar_pkg::VAL_BITS-1:0]        i_sample_value,
    output logic                                 o_div_restart,
    output logic [ttar_pkg::PB_BITS-1:0]         o_plane_bytes,
    output logic [ttar_pkg::RB_BITS-1:0]         o_row_bytes,
    input  logic [ttar_pkg::PB_BITS-1:0]         i_quot,
    input  logic                                 i_quot_done,
    input  logic                                 i_queue_full,
    output logic                                 o_push,
    output ttar_pkg::t_item                      o_item,
    output ttar_pkg::t_front_status              o_status
);
    import ttar_pkg::*;

    logic [DIM_BITS-1:0] r_dim_n, r_dim_c, r_dim_h, r_dim_w;
    logic [PB_BITS-1:0]  r_plane_bytes;
    logic [RB_BITS-1:0]  r_row_bytes;
    t_dir                r_dir;

    logic [COL_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [DIM_BITS-1:0] r_chan, n_chan;
    logic [DIM_BITS-1:0] r_batch, n_batch;
    logic [COL_BITS-1:0] r_spr;
    logic [ROW_BITS-1:0] r_rpp;
    // dims as they stood at the last row-base update
    logic [DIM_BITS-1:0] r_snap_nc, r_snap_nh, r_snap_nw;

    logic [DIM_BITS-1:0] nn, nc, nh, nw;
    logic                start, untile, in_region, emit, final_pos, accept;
    logic [RB_BITS-1:0]  rb_eff;
    logic [COL_BITS-1:0] spr_new, spr_eff, lim_col;
    logic [ROW_BITS-1:0] rpp_eff, lim_row;
    logic [COL_BITS:0]   col_inc;
    logic [ROW_BITS:0]   row_inc;
    logic [DIM_BITS:0]   chan_inc, batch_inc;
    logic                col_wrap, row_wrap, chan_wrap, batch_wrap;

    assign nn = at_least_one(r_dim_n);
    assign nc = at_least_one(r_dim_c);
    assign nh = at_least_one(r_dim_h);
    assign nw = at_least_one(r_dim_w);

    assign start  = (r_col == '0) && (r_row == '0) && (r_chan == '0) && (r_batch == '0);
    assign untile = (r_dir == DIR_UNTILE);

    assign rb_eff  = (r_row_bytes < RB_BITS'(2)) ? RB_BITS'(2) : r_row_bytes;
    assign spr_new = COL_BITS'(rb_eff >> 1);
    assign spr_eff = start ? spr_new : r_spr;
    assign rpp_eff = start ? i_quot : r_rpp;

    assign col_inc   = {1'b0, r_col} + 1'b1;
    assign row_inc   = {1'b0, r_row} + 1'b1;
    assign chan_inc  = {1'b0, r_chan} + 1'b1;
    assign batch_inc = {1'b0, r_batch} + 1'b1;

    assign final_pos = (col_inc >= (COL_BITS+1)'(nw)) && (row_inc >= (ROW_BITS+1)'(nh)) &&
                       (chan_inc >= (DIM_BITS+1)'(nc)) && (batch_inc >= (DIM_BITS+1)'(nn));
    assign in_region = (r_col < COL_BITS'(nw)) && (r_row < ROW_BITS'(nh));
    assign emit      = !untile || in_region;

    assign lim_col = untile ? spr_eff : COL_BITS'(nw);
    assign lim_row = untile ? ((rpp_eff == '0) ? ROW_BITS'(1) : rpp_eff) : ROW_BITS'(nh);

    assign col_wrap   = col_inc >= {1'b0, lim_col};
    assign row_wrap   = row_inc >= {1'b0, lim_row};
    assign chan_wrap  = chan_inc >= {1'b0, nc};
    assign batch_wrap = batch_inc >= {1'b0, nn};

    // a new tensor needs the rows-per-plane quotient settled
    assign o_in_ready = !i_queue_full && !(start && !i_quot_done);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_col   = col_wrap ? '0 : col_inc[COL_BITS-1:0];
        n_row   = r_row;
        n_chan  = r_chan;
        n_batch = r_batch;
        if (col_wrap) begin
            n_row = row_wrap ? '0 : row_inc[ROW_BITS-1:0];
            if (row_wrap) begin
                n_chan = chan_wrap ? '0 : chan_inc[DIM_BITS-1:0];
                if (chan_wrap) begin
                    n_batch = batch_wrap ? '0 : batch_inc[DIM_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_n       <= DIM_BITS'(1);
            r_dim_c       <= DIM_BITS'(1);
            r_dim_h       <= DIM_BITS'(1);
            r_dim_w       <= DIM_BITS'(1);
            r_plane_bytes <= PB_BITS'(2);
            r_row_bytes   <= RB_BITS'(2);
            r_dir         <= DIR_TILE;
            r_col         <= '0;
            r_row         <= '0;
            r_chan        <= '0;
            r_batch       <= '0;
            r_spr         <= COL_BITS'(1);
            r_rpp         <= ROW_BITS'(1);
            r_snap_nc     <= DIM_BITS'(1);
            r_snap_nh     <= DIM_BITS'(1);
            r_snap_nw     <= DIM_BITS'(1);
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_DIM_N:       r_dim_n       <= i_cfg_wdata[DIM_BITS-1:0];
                    CFG_DIM_C:       r_dim_c       <= i_cfg_wdata[DIM_BITS-1:0];
                    CFG_DIM_H:       r_dim_h       <= i_cfg_wdata[DIM_BITS-1:0];
                    CFG_DIM_W:       r_dim_w       <= i_cfg_wdata[DIM_BITS-1:0];
                    CFG_PLANE_BYTES: r_plane_bytes <= i_cfg_wdata[PB_BITS-1:0];
                    CFG_ROW_BYTES:   r_row_bytes   <= i_cfg_wdata[RB_BITS-1:0];
                    CFG_DIRECTION:   r_dir         <= t_dir'(i_cfg_wdata[0]);
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_chan  <= n_chan;
                r_batch <= n_batch;
                if (start) begin
                    r_spr <= spr_new;
                    r_rpp <= i_quot;
                end
                if (col_wrap) begin
                    r_snap_nc <= nc;
                    r_snap_nh <= nh;
                    r_snap_nw <= nw;
                end
            end
        end
    end

    assign o_div_restart = i_cfg_we &&
                           ((t_cfg_reg'(i_cfg_index) == CFG_PLANE_BYTES) ||
                            (t_cfg_reg'(i_cfg_index) == CFG_ROW_BYTES));
    assign o_plane_bytes = r_plane_bytes;
    assign o_row_bytes   = r_row_bytes;

    assign o_push       = accept && emit;
    assign o_item.value = i_sample_value;
    assign o_item.last  = final_pos;
    assign o_item.batch = r_batch;
    assign o_item.chan  = r_chan;
    assign o_item.row   = r_row;
    assign o_item.col   = r_col;
    assign o_item.nc    = r_snap_nc;
    assign o_item.x     = untile ? ROW_BITS'(r_snap_nh) : rpp_eff;
    assign o_item.y     = untile ? COL_BITS'(r_snap_nw) : spr_eff;

    assign o_status.start  = start;
    assign o_status.emit   = emit;
    assign o_status.last   = final_pos;
    assign o_status.untile = untile;

endmodule

// ===== rtl/ttar_queue.sv =====
// Short request queue between the counter front end and the address pipeline.
module ttar_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ttar_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output ttar_pkg::t_item o_item,
    input  logic            i_pop
);
    import ttar_pkg::*;

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 do_pop;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/ttar_back.sv =====
// Address pipeline: plane, row and element index, at most one multiply per stage.
module ttar_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  ttar_pkg::t_item                     i_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ttar_pkg::VAL_BITS-1:0]       o_value,
    output logic [ttar_pkg::INDEX_BITS-1:0]     o_index,
    output logic                                o_last
);
    import ttar_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    // stage 1: plane number
    logic [INDEX_BITS-1:0] r1_plane;
    logic [ROW_BITS-1:0]   r1_row, r1_x;
    logic [COL_BITS-1:0]   r1_col, r1_y;
    logic [VAL_BITS-1:0]   r1_value;
    logic                  r1_last;
    // stage 2: row number within the whole tensor
    logic [INDEX_BITS-1:0] r2_a;
    logic [COL_BITS-1:0]   r2_col, r2_y;
    logic [VAL_BITS-1:0]   r2_value;
    logic                  r2_last;
    // stage 3: row base
    logic [INDEX_BITS-1:0] r3_base;
    logic [COL_BITS-1:0]   r3_col;
    logic [VAL_BITS-1:0]   r3_value;
    logic                  r3_last;
    // stage 4: output register
    logic [INDEX_BITS-1:0] r4_idx;
    logic [VAL_BITS-1:0]   r4_value;
    logic                  r4_last;

    logic [2*DIM_BITS-1:0] mul1;
    logic [INDEX_BITS-1:0] mul2, mul3;

    assign en4 = !r_v4 || i_out_ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;

    assign mul1 = i_item.batch * i_item.nc;
    assign mul2 = r1_plane * INDEX_BITS'(r1_x);
    assign mul3 = r2_a * INDEX_BITS'(r2_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_plane <= INDEX_BITS'(mul1) + INDEX_BITS'(i_item.chan);
            r1_row   <= i_item.row;
            r1_x     <= i_item.x;
            r1_col   <= i_item.col;
            r1_y     <= i_item.y;
            r1_value <= i_item.value;
            r1_last  <= i_item.last;
        end
        if (en2) begin
            r2_a     <= mul2 + INDEX_BITS'(r1_row);
            r2_col   <= r1_col;
            r2_y     <= r1_y;
            r2_value <= r1_value;
            r2_last  <= r1_last;
        end
        if (en3) begin
            r3_base  <= mul3;
            r3_col   <= r2_col;
            r3_value <= r2_value;
            r3_last  <= r2_last;
        end
        if (en4) begin
            r4_idx   <= r3_base + INDEX_BITS'(r3_col);
            r4_value <= r3_value;
            r4_last  <= r3_last;
        end
    end

    assign o_out_valid = r_v4;
    assign o_value     = r4_value;
    assign o_index     = r4_idx;
    assign o_last      = r4_last;

endmodule

// ===== rtl/tensor_tile_address_remap_core.sv =====
// Top level: dense NCHW <-> padded tiled layout address remapper.
//
//  channel | handshake                    | payload
//  --------+------------------------------+--------------------------------------------
//  in      | i_in_valid / o_in_ready      | i_sample_value
//  out     | o_out_valid / i_out_ready    | o_out_value, o_dest_index, o_last_flag
//  cfg     | i_cfg_we (no wait)           | i_cfg_index, i_cfg_wdata
//
// One request per cycle sustained while the queue has room and the quotient is settled; a result
// passes through the queue, three multiply stages and the output register.
// Rows per plane come from a bit-serial divider that reruns after reset and after each
// write of plane_bytes or row_bytes; the first request of a tensor waits for it.
// Reset is synchronous, active low. A 4-deep queue lets the counters keep taking requests
// while the output stalls; untile padding slots are taken without using a queue entry.
module tensor_tile_address_remap_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ttar_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [ttar_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [ttar_pkg::VAL_BITS-1:0]        i_sample_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [ttar_pkg::VAL_BITS-1:0]        o_out_value,
    output logic [ttar_pkg::OUT_IDX_BITS-1:0]    o_dest_index,
    output logic                                 o_last_flag
);
    import ttar_pkg::*;

    logic                  div_restart, quot_done;
    logic [PB_BITS-1:0]    plane_bytes, quot;
    logic [RB_BITS-1:0]    row_bytes;
    logic                  queue_full, push, q_valid, q_pop;
    t_item                 front_item, q_item;
    t_front_status         status;
    logic [INDEX_BITS-1:0] back_index;
    logic                  in_accept;

    ttar_div u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (div_restart),
        .i_plane_bytes (plane_bytes),
        .i_row_bytes   (row_bytes),
        .o_quot        (quot),
        .o_done        (quot_done)
    );

    ttar_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .o_div_restart  (div_restart),
        .o_plane_bytes  (plane_bytes),
        .o_row_bytes    (row_bytes),
        .i_quot         (quot),
        .i_quot_done    (quot_done),
        .i_queue_full   (queue_full),
        .o_push         (push),
        .o_item         (front_item),
        .o_status       (status)
    );

    ttar_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    ttar_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (q_pop),
        .i_item      (q_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_out_value),
        .o_index     (back_index),
        .o_last      (o_last_flag)
    );

    assign o_dest_index = OUT_IDX_BITS'(back_index);
    assign in_accept    = i_in_valid && o_in_ready;

    // a geometry write must invalidate the quotient right away
    a_div_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_restart |=> !quot_done)
        else $error("quotient still marked done after geometry write");

    // tile mode produces a result for every request
    a_tile_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !status.untile) |-> push)
        else $error("tile-mode request dropped");

    // in tile mode the final element wraps every counter
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !status.untile && status.last) |=> status.start)
        else $error("counters did not wrap after final element");

endmodule
